// ===== rtl/assert_macros.svh =====
// Assertion helpers included by activity_debounce_hysteresis_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while the block is out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/adh_pkg.sv =====
package adh_pkg;

    // Slot table size and field widths.
    localparam int SLOTS      = 8;
    localparam int SLOT_W     = 3;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TIME_W     = 32;
    localparam int RUN_W      = 4;
    localparam int FLAP_W     = 8;
    localparam int NEED_W     = 3;
    localparam int DEB_W      = 16;
    localparam int WIN_W      = 20;
    localparam int LIMIT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Saturation limits of the per-slot counters.
    localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
    localparam logic [FLAP_W-1:0] FLAP_MAX = '1;

    // Register values after reset.
    localparam logic [DEB_W-1:0]   DEBOUNCE_RST     = DEB_W'(3000);
    localparam logic [DEB_W-1:0]   EXT_DEBOUNCE_RST = DEB_W'(8000);
    localparam logic [DEB_W-1:0]   HOLD_RST         = DEB_W'(5000);
    localparam logic [WIN_W-1:0]   FLAP_WINDOW_RST  = WIN_W'(10000);
    localparam logic [LIMIT_W-1:0] FLAP_LIMIT_RST   = LIMIT_W'(5);
    localparam logic [NEED_W-1:0]  NEED_ACTIVE_RST  = NEED_W'(2);
    localparam logic [NEED_W-1:0]  NEED_INACTIVE_RST = NEED_W'(4);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE      = 3'd0,
        CFG_EXT_DEBOUNCE  = 3'd1,
        CFG_HOLD          = 3'd2,
        CFG_FLAP_WINDOW   = 3'd3,
        CFG_FLAP_LIMIT    = 3'd4,
        CFG_NEED_ACTIVE   = 3'd5,
        CFG_NEED_INACTIVE = 3'd6
    } t_cfg_idx;

    // One poll as carried on the input channel.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              is_wireless;
        logic              raw_active;
        logic [TIME_W-1:0] now_ms;
    } t_poll;

    // Tracking state of one slot.
    typedef struct packed {
        logic              confirmed_active;
        logic              reported_active;
        logic [TIME_W-1:0] change_time;
        logic [TIME_W-1:0] activity_time;
        logic [TIME_W-1:0] window_start;
        logic [RUN_W-1:0]  active_run;
        logic [RUN_W-1:0]  inactive_run;
        logic [FLAP_W-1:0] flap_count;
    } t_slot_state;

    // Increment that stops at the given cap.
    function automatic logic [RUN_W-1:0] sat_inc_run(input logic [RUN_W-1:0] v,
                                                     input logic [RUN_W-1:0] cap);
        return (v >= cap) ? cap : v + RUN_W'(1);
    endfunction

endpackage

// ===== rtl/adh_poll_if.sv =====
interface adh_poll_if;
    logic                        valid;
    logic                        ready;
    logic [adh_pkg::SLOT_W-1:0]  slot;
    logic                        is_wireless;
    logic                        raw_active;
    logic [adh_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, output slot, output is_wireless, output raw_active,
                    output now_ms, input ready);
    modport sink   (input valid, input slot, input is_wireless, input raw_active,
                    input now_ms, output ready);
endinterface

// ===== rtl/adh_report_if.sv =====
interface adh_report_if;
    logic valid;
    logic ready;
    logic report_active;

    modport source (output valid, output report_active, input ready);
    modport sink   (input valid, input report_active, output ready);
endinterface

// ===== rtl/activity_debounce_hysteresis_unit.sv =====
// Per-slot activity qualifier.
// Polls arrive on i_poll (valid/ready); each carries a slot number, a wireless
// flag, a raw activity bit and a free-running millisecond timestamp. Every
// accepted poll yields exactly one transaction on o_report with the qualified
// activity bit, in poll order. Non-wireless polls return the raw bit and leave
// the slot state alone; wireless polls run the count hysteresis, hold time and
// flap-extended debounce against the slot's stored state.
// A poll is captured in an input register, evaluated combinationally against
// the slot table, and its result lands in the output register when that is
// free or being emptied. One poll per cycle is sustained while not stalled;
// the slot table is written in the cycle the result is registered, so a
// following poll to the same slot sees the update with no bubble.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more poll; after that i_poll.ready falls
// until the result is taken.
// Reset empties both pipeline registers, marks all slots unseen and loads the
// register defaults. Configuration writes on i_cfg_* take effect at the next
// edge and are expected only while no poll is in flight.
module activity_debounce_hysteresis_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    adh_poll_if.sink                         i_poll,
    adh_report_if.source                     o_report,
    input  logic                             i_cfg_we,
    input  logic [adh_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [adh_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration registers.
    logic [adh_pkg::DEB_W-1:0]   r_debounce_ms;
    logic [adh_pkg::DEB_W-1:0]   r_ext_debounce_ms;
    logic [adh_pkg::DEB_W-1:0]   r_hold_ms;
    logic [adh_pkg::WIN_W-1:0]   r_flap_window_ms;
    logic [adh_pkg::LIMIT_W-1:0] r_flap_limit;
    logic [adh_pkg::NEED_W-1:0]  r_need_active;
    logic [adh_pkg::NEED_W-1:0]  r_need_inactive;

    // Slot table.
    logic [adh_pkg::SLOTS-1:0]  r_slot_valid;
    adh_pkg::t_slot_state       r_state [adh_pkg::SLOTS];

    // Pipeline registers.
    logic                       r_in_valid;
    adh_pkg::t_poll             r_in;
    logic                       r_out_valid;
    logic                       r_out_active;

    // Evaluation signals.
    logic                       w_advance;
    logic                       w_in_take;
    logic                       w_tracked;
    logic [adh_pkg::IDX_W-1:0]  w_idx;
    adh_pkg::t_slot_state       w_cur;
    adh_pkg::t_slot_state       n_state;
    logic                       n_out_active;
    logic [adh_pkg::TIME_W-1:0] w_since_change;
    logic [adh_pkg::TIME_W-1:0] w_since_act;
    logic [adh_pkg::TIME_W-1:0] w_since_window;
    logic [adh_pkg::FLAP_W-1:0] w_flap;
    logic [adh_pkg::DEB_W-1:0]  w_eff_debounce;
    logic                       w_in_hold;
    logic [adh_pkg::RUN_W-1:0]  w_run;

    // Handshake: the input register drains whenever the output register is
    // free or being emptied in the same cycle.
    assign w_advance      = r_in_valid && (!r_out_valid || o_report.ready);
    assign i_poll.ready   = !r_in_valid || w_advance;
    assign w_in_take      = i_poll.valid && i_poll.ready;
    assign o_report.valid = r_out_valid;
    assign o_report.report_active = r_out_active;

    // Only wireless polls to an existing slot touch the table.
    assign w_tracked = r_in.is_wireless && (int'(r_in.slot) < adh_pkg::SLOTS);
    assign w_idx     = adh_pkg::IDX_W'(r_in.slot);

    // Qualification rule for the poll held in the input register.
    always_comb begin
        w_cur = r_state[w_idx];
        if (!r_slot_valid[w_idx]) begin
            w_cur.confirmed_active = 1'b0;
            w_cur.reported_active  = 1'b0;
            w_cur.change_time      = r_in.now_ms;
            w_cur.activity_time    = r_in.now_ms;
            w_cur.window_start     = r_in.now_ms;
            w_cur.active_run       = '0;
            w_cur.inactive_run     = '0;
            w_cur.flap_count       = '0;
        end

        w_since_change = r_in.now_ms - w_cur.change_time;
        w_since_act    = r_in.now_ms - w_cur.activity_time;
        w_since_window = r_in.now_ms - w_cur.window_start;
        w_in_hold      = w_since_act < adh_pkg::TIME_W'(r_hold_ms);

        n_state = w_cur;

        // Restart the flap window once it has run out.
        if (w_since_window > adh_pkg::TIME_W'(r_flap_window_ms)) begin
            n_state.flap_count   = '0;
            n_state.window_start = r_in.now_ms;
        end
        w_flap = n_state.flap_count;
        if (r_in.raw_active) begin
            n_state.activity_time = r_in.now_ms;
        end
        w_eff_debounce = (w_flap >= r_flap_limit) ? r_ext_debounce_ms : r_debounce_ms;

        w_run        = '0;
        n_out_active = w_cur.reported_active;

        if (r_in.raw_active != w_cur.confirmed_active) begin
            // Raw bit disagrees with the confirmed state: count a flap.
            n_state.flap_count = (w_flap >= adh_pkg::FLAP_MAX) ? adh_pkg::FLAP_MAX
                                                               : w_flap + adh_pkg::FLAP_W'(1);
            if (r_in.raw_active) begin
                w_run = adh_pkg::sat_inc_run(w_cur.active_run, adh_pkg::RUN_MAX);
                n_state.active_run   = w_run;
                n_state.inactive_run = '0;
                if (w_run >= adh_pkg::RUN_W'(r_need_active)) begin
                    n_state.confirmed_active = 1'b1;
                    n_state.reported_active  = 1'b1;
                    n_state.change_time      = r_in.now_ms;
                    n_out_active             = 1'b1;
                end
            end else begin
                w_run = adh_pkg::sat_inc_run(w_cur.inactive_run, adh_pkg::RUN_MAX);
                n_state.inactive_run = w_run;
                n_state.active_run   = '0;
                if (w_in_hold) begin
                    n_out_active = 1'b1;
                end else if (w_since_change < adh_pkg::TIME_W'(w_eff_debounce)) begin
                    n_out_active = w_cur.reported_active;
                end else if (w_run >= adh_pkg::RUN_W'(r_need_inactive)) begin
                    n_state.confirmed_active = 1'b0;
                    n_state.reported_active  = 1'b0;
                    n_state.change_time      = r_in.now_ms;
                    n_out_active             = 1'b0;
                end
            end
        end else if (r_in.raw_active) begin
            // Steady active: run capped just above the threshold.
            w_run = adh_pkg::sat_inc_run(w_cur.active_run,
                                         adh_pkg::RUN_W'(r_need_active) + adh_pkg::RUN_W'(1));
            n_state.inactive_run = '0;
            n_state.active_run   = w_run;
            if (w_run >= adh_pkg::RUN_W'(r_need_active)) begin
                n_state.reported_active = 1'b1;
                n_out_active            = 1'b1;
            end
        end else if (w_in_hold) begin
            n_out_active = 1'b1;
        end else begin
            // Steady inactive outside the hold time.
            w_run = adh_pkg::sat_inc_run(w_cur.inactive_run,
                                         adh_pkg::RUN_W'(r_need_inactive) + adh_pkg::RUN_W'(1));
            n_state.active_run   = '0;
            n_state.inactive_run = w_run;
        end

        if (!w_tracked) begin
            n_out_active = r_in.raw_active;
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms     <= adh_pkg::DEBOUNCE_RST;
            r_ext_debounce_ms <= adh_pkg::EXT_DEBOUNCE_RST;
            r_hold_ms         <= adh_pkg::HOLD_RST;
            r_flap_window_ms  <= adh_pkg::FLAP_WINDOW_RST;
            r_flap_limit      <= adh_pkg::FLAP_LIMIT_RST;
            r_need_active     <= adh_pkg::NEED_ACTIVE_RST;
            r_need_inactive   <= adh_pkg::NEED_INACTIVE_RST;
        end else if (i_cfg_we) begin
            unique case (adh_pkg::t_cfg_idx'(i_cfg_idx))
                adh_pkg::CFG_DEBOUNCE: begin
                    r_debounce_ms <= i_cfg_data[adh_pkg::DEB_W-1:0];
                end
                adh_pkg::CFG_EXT_DEBOUNCE: begin
                    r_ext_debounce_ms <= i_cfg_data[adh_pkg::DEB_W-1:0];
                end
                adh_pkg::CFG_HOLD: begin
                    r_hold_ms <= i_cfg_data[adh_pkg::DEB_W-1:0];
                end
                adh_pkg::CFG_FLAP_WINDOW: begin
                    r_flap_window_ms <= i_cfg_data[adh_pkg::WIN_W-1:0];
                end
                adh_pkg::CFG_FLAP_LIMIT: begin
                    r_flap_limit <= i_cfg_data[adh_pkg::LIMIT_W-1:0];
                end
                adh_pkg::CFG_NEED_ACTIVE: begin
                    r_need_active <= i_cfg_data[adh_pkg::NEED_W-1:0];
                end
                adh_pkg::CFG_NEED_INACTIVE: begin
                    r_need_inactive <= i_cfg_data[adh_pkg::NEED_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input and output pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_report.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.slot        <= i_poll.slot;
            r_in.is_wireless <= i_poll.is_wireless;
            r_in.raw_active  <= i_poll.raw_active;
            r_in.now_ms      <= i_poll.now_ms;
        end
        if (w_advance) begin
            r_out_active <= n_out_active;
        end
    end

    // Slot seen flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (w_advance && w_tracked) begin
            r_slot_valid[w_idx] <= 1'b1;
        end
    end

    // Slot state, written as the result is registered.
    always_ff @(posedge i_clk) begin
        if (w_advance && w_tracked) begin
            r_state[w_idx] <= n_state;
        end
    end

`include "assert_macros.svh"

    `ASSERT_ANY(a_rst_empties_pipe, !i_rst_n |=> (!r_in_valid && !r_out_valid), "pipeline not empty after reset")
    `ASSERT_CLK(a_no_overrun, (r_in_valid && r_out_valid && !o_report.ready) |-> !i_poll.ready, "poll taken while pipeline is full")
    `ASSERT_CLK(a_bypass_raw, (w_advance && !r_in.is_wireless) |=> (r_out_active == $past(r_in.raw_active)), "non-wireless poll result differs from raw bit")
    `ASSERT_CLK(a_seen_sticky, 1'b1 |=> (($past(r_slot_valid) & ~r_slot_valid) == '0), "slot seen flag cleared outside reset")

endmodule
